### rtl/core/pcpa_pkg.sv
package pcpa_pkg;

  localparam int unsigned NUM_CPUS_DEF    = 8;
  localparam int unsigned NUM_PAGES_DEF   = 32768;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned STEAL_STEPS_DEF = 1024;

  localparam logic ACTION_FREE  = 1'b0;
  localparam logic ACTION_ALLOC = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FAIL = 2'd1;
  localparam logic [1:0] STATUS_BAD  = 2'd2;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_STOP  = 1'b1;

  localparam logic [31:0] REGION_START_RST = 32'h8000_0000;
  localparam logic [31:0] REGION_STOP_RST  = 32'h8800_0000;

  typedef struct packed {
    logic        action;
    logic [2:0]  cpu;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] page_address;
  } res_t;

  typedef struct packed {
    logic capture;
    logic free_push;
    logic bad_free;
    logic fail;
    logic pop_read;
    logic pop_done;
    logic use_victim;
    logic scan_init;
    logic scan_next;
    logic steal_start;
    logic walk_step;
    logic steal_done;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic cpu_ok;
    logic free_bad;
    logic own_ok;
    logic scan_hit;
    logic scan_last;
    logic walk_more;
  } sts_t;

endpackage

### rtl/core/pcpa_ctrl.sv
module pcpa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  pcpa_pkg::sts_t   sts_i,
  output pcpa_pkg::cmd_t   cmd_o,
  output logic             busy_o
);
  import pcpa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_POP,
    S_SCAN,
    S_WALK
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!sts_i.is_alloc) begin
          if (sts_i.free_bad) begin
            cmd_o.bad_free = 1'b1;
          end else begin
            cmd_o.free_push = 1'b1;
          end
          state_d = S_IDLE;
        end else if (!sts_i.cpu_ok) begin
          cmd_o.fail = 1'b1;
          state_d    = S_IDLE;
        end else if (sts_i.own_ok) begin
          cmd_o.pop_read = 1'b1;
          state_d        = S_POP;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_POP: begin
        cmd_o.pop_done = 1'b1;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.use_victim = 1'b1;
        priority if (sts_i.scan_hit) begin
          cmd_o.steal_start = 1'b1;
          state_d           = S_WALK;
        end else if (sts_i.scan_last) begin
          cmd_o.fail = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_WALK: begin
        if (sts_i.walk_more) begin
          cmd_o.walk_step = 1'b1;
        end else begin
          cmd_o.steal_done = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

### rtl/core/pcpa_dp.sv
module pcpa_dp #(
  parameter int unsigned NUM_CPUS    = pcpa_pkg::NUM_CPUS_DEF,
  parameter int unsigned NUM_PAGES   = pcpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES  = pcpa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned STEAL_STEPS = pcpa_pkg::STEAL_STEPS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcpa_pkg::req_t                   req_i,
  input  logic                             cfg_valid_i,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  pcpa_pkg::cmd_t                   cmd_i,
  output pcpa_pkg::sts_t                   sts_o,
  output logic                             res_valid_o,
  output pcpa_pkg::res_t                   res_o
);
  import pcpa_pkg::*;

  localparam int unsigned PW  = $clog2(NUM_PAGES);
  localparam int unsigned CW  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int unsigned SH  = $clog2(PAGE_BYTES);
  localparam int unsigned APW = 32 - SH;
  localparam int unsigned BPW = 33 - SH;
  localparam int unsigned JW  = $clog2(STEAL_STEPS + 1);

  typedef struct packed {
    logic          ok;
    logic [PW-1:0] link;
  } link_t;

  logic [31:0]   start_q, stop_q;
  logic          action_q;
  logic [2:0]    cpu_q;
  logic [31:0]   addr_q;
  logic [CW-1:0] v_q;
  logic [PW-1:0] t_q, p_q, first_q;
  logic [JW-1:0] j_q;
  res_t          res_q;
  logic          res_valid_q;

  logic [PW-1:0]       head_q [NUM_CPUS];
  logic [NUM_CPUS-1:0] ok_q;

  link_t mem_q [NUM_PAGES];
  link_t rd_q;

  logic [BPW-1:0] base_pg;
  logic [APW-1:0] addr_pg;
  logic [BPW-1:0] idx_full;
  logic [CW-1:0]  c_idx;
  logic [CW-1:0]  head_idx;
  logic [PW-1:0]  head_rd;
  logic           ok_rd;
  logic           cpu_ok;
  logic [32:0]    grant_pg;
  logic [31:0]    grant_addr;

  logic          mem_we, mem_re;
  logic [PW-1:0] mem_waddr, mem_raddr;
  link_t         mem_wdata;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= REGION_START_RST;
      stop_q  <= REGION_STOP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_REGION_START: start_q <= cfg_data_i;
        CFG_REGION_STOP:  stop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign base_pg  = BPW'((33'(start_q) + 33'(PAGE_BYTES - 1)) >> SH);
  assign addr_pg  = addr_q[31:SH];
  assign idx_full = BPW'(addr_pg) - base_pg;
  assign c_idx    = CW'(cpu_q);
  assign cpu_ok   = (32'(cpu_q) < NUM_CPUS);

  assign head_idx = cmd_i.use_victim ? v_q : c_idx;
  assign head_rd  = head_q[head_idx];
  assign ok_rd    = ok_q[head_idx];

  assign grant_pg   = 33'(base_pg) + 33'(p_q);
  assign grant_addr = 32'(grant_pg << SH);

  assign sts_o.is_alloc  = (action_q == ACTION_ALLOC);
  assign sts_o.cpu_ok    = cpu_ok;
  assign sts_o.free_bad  = !cpu_ok || (addr_q[SH-1:0] != '0) || (addr_q < start_q) ||
                           (addr_q >= stop_q) || (33'(idx_full) >= 33'(NUM_PAGES));
  assign sts_o.own_ok    = ok_rd;
  assign sts_o.scan_hit  = ok_rd && (v_q != c_idx);
  assign sts_o.scan_last = (v_q == CW'(NUM_CPUS - 1));
  assign sts_o.walk_more = rd_q.ok && (j_q != JW'(STEAL_STEPS));

  // next-link memory
  assign mem_we    = cmd_i.free_push | cmd_i.steal_done;
  assign mem_waddr = cmd_i.free_push ? PW'(idx_full) : t_q;
  assign mem_wdata = cmd_i.free_push ? link_t'{ok: ok_rd, link: head_rd}
                                     : link_t'{ok: 1'b0, link: rd_q.link};
  assign mem_re    = cmd_i.pop_read | cmd_i.steal_start | cmd_i.walk_step;
  assign mem_raddr = cmd_i.walk_step ? rd_q.link : head_rd;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  // list heads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= '0;
    end else begin
      if (cmd_i.free_push) begin
        ok_q[c_idx] <= 1'b1;
      end
      if (cmd_i.pop_done) begin
        ok_q[c_idx] <= rd_q.ok;
      end
      if (cmd_i.steal_done) begin
        ok_q[v_q]   <= rd_q.ok;
        ok_q[c_idx] <= (t_q != p_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.free_push) begin
      head_q[c_idx] <= PW'(idx_full);
    end
    if (cmd_i.pop_done) begin
      head_q[c_idx] <= rd_q.link;
    end
    if (cmd_i.steal_done) begin
      head_q[v_q]   <= rd_q.link;
      head_q[c_idx] <= first_q;
    end
  end

  // item and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= req_i.action;
      cpu_q    <= req_i.cpu;
      addr_q   <= req_i.address;
    end
    if (cmd_i.pop_read) begin
      p_q <= head_rd;
    end
    if (cmd_i.scan_init) begin
      v_q <= '0;
    end else if (cmd_i.scan_next) begin
      v_q <= v_q + CW'(1);
    end
    if (cmd_i.steal_start) begin
      t_q <= head_rd;
      p_q <= head_rd;
      j_q <= '0;
    end else if (cmd_i.walk_step) begin
      t_q <= rd_q.link;
      j_q <= j_q + JW'(1);
      if (j_q == '0) begin
        first_q <= rd_q.link;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.free_push | cmd_i.bad_free | cmd_i.fail |
                     cmd_i.pop_done | cmd_i.steal_done;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.pop_done || cmd_i.steal_done) begin
      res_q <= res_t'{status: STATUS_OK, page_address: grant_addr};
    end else if (cmd_i.free_push) begin
      res_q <= res_t'{status: STATUS_OK, page_address: 32'd0};
    end else if (cmd_i.bad_free) begin
      res_q <= res_t'{status: STATUS_BAD, page_address: 32'd0};
    end else if (cmd_i.fail) begin
      res_q <= res_t'{status: STATUS_FAIL, page_address: 32'd0};
    end else begin
      res_q <= res_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

### rtl/core/per_cpu_page_allocator_with_stealing_core.sv
// channel   direction  handshake                    payload
// request   in         start_i high, busy_o low     req_i (action, cpu, address)
// result    out        res_valid_o for one cycle    res_o (status, page_address)
// config    in         cfg_valid_i and cfg_ready_o  cfg_index_i, cfg_data_i
//
// free: accept then address check and push
// alloc from own list: accept, check, then one read of the next-link memory
// alloc by steal: accept, check, scan cpus in order, walk links (up to 1024), one link per cycle
// reset marks every list empty; the list head pointers and the next-link memory are left unset
// the result receiver cannot stall; config is always ready
module per_cpu_page_allocator_with_stealing_core #(
  parameter int unsigned NUM_CPUS    = pcpa_pkg::NUM_CPUS_DEF,
  parameter int unsigned NUM_PAGES   = pcpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_BYTES  = pcpa_pkg::PAGE_BYTES_DEF,
  parameter int unsigned STEAL_STEPS = pcpa_pkg::STEAL_STEPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  pcpa_pkg::req_t                 req_i,
  output logic                           res_valid_o,
  output pcpa_pkg::res_t                 res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pcpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);
  import pcpa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  pcpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  pcpa_dp #(
    .NUM_CPUS   (NUM_CPUS),
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_BYTES (PAGE_BYTES),
    .STEAL_STEPS(STEAL_STEPS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  a_res_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o)
    else $error("result shown while busy");

  a_res_spaced : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("results in consecutive cycles");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !res_valid_o))
    else $error("accepted item not worked on");

  a_no_grant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != STATUS_OK)) |-> (res_o.page_address == 32'd0))
    else $error("address given with failed item");

endmodule

### tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcpa_pkg::*;

  localparam int unsigned NCPU = NUM_CPUS_DEF;
  localparam int unsigned NPAGES = NUM_PAGES_DEF;
  localparam int unsigned PAGE = PAGE_BYTES_DEF;
  localparam int unsigned WALK_MAX = STEAL_STEPS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef bit [$clog2(NPAGES)-1:0] page_t;

  typedef struct {
    res_t res;
    logic from_alloc;
  } due_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  req_t        req_i = '0;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  page_t       next_link [NPAGES];
  bit          link_valid [NPAGES];
  page_t       list_top [NCPU];
  bit          list_live [NCPU];
  logic [31:0] cfg_start = REGION_START_RST;
  logic [31:0] cfg_stop = REGION_STOP_RST;

  req_t        queued_reqs [$];
  due_t        due_results [$];
  logic [31:0] held_pages [$];
  due_t        oldest_due;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_left = 0;
  bit          idle_on = 1'b1;

  per_cpu_page_allocator_with_stealing_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint unsigned region_base();
    longint unsigned b;
    b = {32'd0, cfg_start} + PAGE - 1;
    return b / PAGE * PAGE;
  endfunction

  // refill an empty list from the first non-empty list of another cpu
  function automatic void steal_chain(int unsigned c);
    page_t t;
    for (int unsigned v = 0; v < NCPU; v++) begin
      if (v == c || !list_live[v]) continue;
      t = list_top[v];
      for (int unsigned j = 0; j < WALK_MAX; j++) begin
        if (!link_valid[t]) break;
        t = next_link[t];
      end
      list_top[c] = list_top[v];
      list_live[c] = 1'b1;
      if (link_valid[t]) begin
        list_top[v] = next_link[t];
      end else begin
        list_live[v] = 1'b0;
      end
      link_valid[t] = 1'b0;
      return;
    end
  endfunction

  function automatic res_t grant_for(req_t r);
    longint unsigned base;
    longint unsigned idx;
    page_t p;
    res_t res;
    base = region_base();
    res.status = STATUS_OK;
    res.page_address = '0;
    if (r.action == ACTION_FREE) begin
      if (r.address % PAGE != 0 || r.address < cfg_start || r.address >= cfg_stop) begin
        res.status = STATUS_BAD;
        return res;
      end
      idx = ({32'd0, r.address} - base) / PAGE;
      if (idx >= NPAGES) begin
        res.status = STATUS_BAD;
        return res;
      end
      next_link[idx] = list_top[r.cpu];
      link_valid[idx] = list_live[r.cpu];
      list_top[r.cpu] = page_t'(idx);
      list_live[r.cpu] = 1'b1;
      return res;
    end
    if (!list_live[r.cpu]) steal_chain(r.cpu);
    if (!list_live[r.cpu]) begin
      res.status = STATUS_FAIL;
      return res;
    end
    p = list_top[r.cpu];
    if (link_valid[p]) begin
      list_top[r.cpu] = next_link[p];
    end else begin
      list_live[r.cpu] = 1'b0;
    end
    res.page_address = 32'(base + longint'(p) * PAGE);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
      req_i <= '0;
      gap_left <= 0;
    end else begin
      if (start_i && !busy_o) begin
        due_results.push_back('{res: grant_for(req_i), from_alloc: req_i.action == ACTION_ALLOC});
      end
      if (start_i && busy_o) begin
        start_i <= 1'b1;
      end else if (gap_left > 0) begin
        start_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (queued_reqs.size() > 0) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
          start_i <= 1'b0;
          gap_left <= $urandom_range(0, 4);
        end else begin
          start_i <= 1'b1;
          req_i <= queued_reqs.pop_front();
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (due_results.size() == 0) begin
        report_mismatch("unexpected item", {30'd0, res_o.status}, '0);
      end else begin
        oldest_due = due_results.pop_front();
        if (res_o.status !== oldest_due.res.status)
          report_mismatch("status", {30'd0, res_o.status}, {30'd0, oldest_due.res.status});
        if (res_o.page_address !== oldest_due.res.page_address)
          report_mismatch("page_address", res_o.page_address, oldest_due.res.page_address);
        if (oldest_due.from_alloc && oldest_due.res.status == STATUS_OK)
          held_pages.push_back(oldest_due.res.page_address);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_item(logic act, logic [2:0] cpu, logic [31:0] addr);
    req_t r;
    r.action = act;
    r.cpu = cpu;
    r.address = addr;
    while (queued_reqs.size() >= 4) @(posedge clk_i);
    queued_reqs.push_back(r);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (queued_reqs.size() != 0 || due_results.size() != 0 || start_i || busy_o
           || res_valid_o);
  endtask

  task automatic set_region(logic [31:0] lo, logic [31:0] hi);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_REGION_START;
    cfg_data_i <= lo;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_start = lo;
    cfg_index_i <= CFG_REGION_STOP;
    cfg_data_i <= hi;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_stop = hi;
    cfg_valid_i <= 1'b0;
    held_pages.delete();
  endtask

  task automatic fill_held(int unsigned first, int unsigned count);
    longint unsigned a;
    for (int unsigned k = 0; k < count; k++) begin
      a = region_base() + longint'(first + k) * PAGE;
      if (a <= 64'hFFFF_FFFF) held_pages.push_back(a[31:0]);
    end
  endtask

  task automatic queue_random_item();
    int unsigned roll;
    int unsigned k;
    int unsigned n;
    logic [2:0] cpu;
    logic [31:0] addr;
    roll = $urandom_range(0, 99);
    cpu = 3'($urandom_range(0, NCPU - 1));
    if (roll < 4 && held_pages.size() >= 8) begin
      // run of frees onto one list
      n = $urandom_range(4, 16);
      while (n > 0 && held_pages.size() > 0) begin
        k = $urandom_range(0, held_pages.size() - 1);
        addr = held_pages[k];
        held_pages.delete(k);
        queue_item(ACTION_FREE, cpu, addr);
        n--;
      end
    end else if (roll < 48 || (roll < 90 && held_pages.size() == 0)) begin
      queue_item(ACTION_ALLOC, cpu, $urandom());
    end else if (roll < 90) begin
      k = $urandom_range(0, held_pages.size() - 1);
      addr = held_pages[k];
      held_pages.delete(k);
      queue_item(ACTION_FREE, cpu, addr);
    end else begin
      // malformed or repeated frees
      case ($urandom_range(0, 4))
        0: addr = $urandom();
        1: addr = 32'(region_base()) + $urandom_range(0, 127) * PAGE;
        2: addr = 32'(region_base()) + $urandom_range(0, 127) * PAGE
                  + $urandom_range(1, PAGE - 1);
        3: addr = (cfg_stop + PAGE - 1) & ~32'(PAGE - 1);
        default: addr = (cfg_start - 1) & ~32'(PAGE - 1);
      endcase
      queue_item(ACTION_FREE, cpu, addr);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_item(ACTION_ALLOC, 3'd0, 32'h0000_0000);
    queue_item(ACTION_FREE, 3'd2, 32'h8000_0001);
    queue_item(ACTION_FREE, 3'd2, 32'h7FFF_F000);
    queue_item(ACTION_FREE, 3'd2, 32'h8800_0000);
    queue_item(ACTION_FREE, 3'd2, 32'hFFFF_FFFF);
    queue_item(ACTION_FREE, 3'd2, 32'h0000_0000);
    queue_item(ACTION_FREE, 3'd0, 32'h8000_0000);
    queue_item(ACTION_FREE, 3'd7, 32'h87FF_F000);
    queue_item(ACTION_ALLOC, 3'd7, 32'hFFFF_FFFF);
    queue_item(ACTION_ALLOC, 3'd0, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd0, 32'h5555_AAAA);
    // double free makes a loop, so the steal walk hits its bound
    queue_item(ACTION_FREE, 3'd0, 32'h8000_1000);
    queue_item(ACTION_FREE, 3'd0, 32'h8000_2000);
    queue_item(ACTION_FREE, 3'd0, 32'h8000_1000);
    queue_item(ACTION_ALLOC, 3'd1, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd1, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd1, 32'h0000_0000);
    // victims are scanned in cpu order
    queue_item(ACTION_FREE, 3'd5, 32'h8000_5000);
    queue_item(ACTION_FREE, 3'd3, 32'h8000_3000);
    queue_item(ACTION_FREE, 3'd3, 32'h8000_4000);
    queue_item(ACTION_ALLOC, 3'd6, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd6, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd6, 32'h0000_0000);
    queue_item(ACTION_ALLOC, 3'd6, 32'h0000_0000);
    wait_idle();

    fill_held(64, 48);
    repeat (130) queue_random_item();
    wait_idle();

    set_region(32'h0000_0000, 32'hFFFF_FFFF);
    fill_held(0, 40);
    fill_held(NPAGES - 8, 16);
    repeat (80) queue_random_item();
    wait_idle();

    set_region(32'h1234_5001, 32'h9234_6000);
    fill_held(0, 48);
    repeat (80) queue_random_item();
    wait_idle();

    set_region(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (40) queue_random_item();
    wait_idle();

    set_region(32'hF000_0000, 32'hFFFF_F000);
    fill_held(0, 32);
    fill_held(NPAGES - 8, 16);
    repeat (70) queue_random_item();
    wait_idle();

    set_region(REGION_START_RST, REGION_STOP_RST);
    idle_on = 1'b0;
    fill_held(200, 32);
    repeat (45) queue_random_item();
    wait_idle();

    repeat (1100) @(posedge clk_i);
    if (due_results.size() != 0)
      report_mismatch("items never returned", 32'(due_results.size()), '0);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
